>>> design/nmea_gga_field_extractor_defines.svh
// Assertion macros shared by the GGA field extractor RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef NMEA_GGA_FIELD_EXTRACTOR_DEFINES_SVH
`define NMEA_GGA_FIELD_EXTRACTOR_DEFINES_SVH

// same-cycle implication
`define NGGA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NGGA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/ngga_pkg.sv
// Types and constants of the GGA field extractor.
// Used by ngga_parse, ngga_out_reg and the top level; no dependencies.
package ngga_pkg;

   localparam int TAG_W    = 40;
   localparam int HDR_LEN  = 5;
   localparam int BODY_POS = 6;
   localparam int TIME_LEN = 10;
   localparam int LAT_LEN  = 9;
   localparam int LON_LEN  = 10;
   localparam int TDATA_W  = 240;

   localparam logic [TAG_W-1:0] TAG_RESET = 40'h4750474741;  // "GPGGA"

   localparam logic [7:0] START_CHAR = 8'h24;  // '$'
   localparam logic [7:0] SEP_CHAR   = 8'h2C;  // ','
   localparam logic [7:0] ZERO_CHAR  = 8'h30;  // '0'

   localparam logic [2:0] FLD_TIME  = 3'd0;
   localparam logic [2:0] FLD_LAT   = 3'd1;
   localparam logic [2:0] FLD_LON   = 3'd3;
   localparam logic [2:0] FLD_SATS  = 3'd6;
   localparam logic [2:0] FIELD_MAX = 3'd7;
   localparam logic [3:0] CHAR_MAX  = 4'hF;

   typedef logic [7:0] byte_type;

   typedef struct packed {
      logic [7:0]  sats_char;
      logic [39:0] lon_tail;
      logic [39:0] lon_head;
      logic [31:0] lat_tail;
      logic [39:0] lat_head;
      logic [31:0] time_tail;
      logic [47:0] time_head;
   } ngga_rec_type;

   typedef struct packed {
      ngga_rec_type rec;
      logic         sentence_seen;
   } ngga_rsp_type;

endpackage

>>> design/nmea_gga_field_extractor.sv
// GGA field extractor: takes one received byte per word and emits one packed record of time,
// latitude, longitude and satellite char at each end-of-buffer byte. A byte is registered on
// entry and parsed from that register; if it ends the buffer, the record lands in the result register
// and is offered from it. One byte per cycle is taken while the input is not stalled; the parse
// state updates once per cycle while bytes flow. The input stalls only when an end-of-buffer
// byte waits for a result register still held by the consumer. No clearing pass after reset.
// Depends on ngga_pkg, ngga_parse, ngga_out_reg and nmea_gga_field_extractor_defines.svh.
`include "nmea_gga_field_extractor_defines.svh"

module nmea_gga_field_extractor (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [7:0] rx_byte
   input  logic                         req_tlast,   // end_of_buffer
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [47:0] time_head, [79:48] time_tail, [119:80] lat_head, [151:120] lat_tail,
   // [191:152] lon_head, [231:192] lon_tail, [239:232] sats_char
   output logic [ngga_pkg::TDATA_W-1:0] rsp_tdata,
   output logic [0:0]                   rsp_tuser,   // [0] sentence_seen
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ngga_pkg::TAG_W-1:0]   csr_data     // sentence_tag
);
   import ngga_pkg::*;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;
   logic [TAG_W-1:0] tag_ff;
   logic             proc;
   ngga_rsp_type     rsp_next;
   ngga_rsp_type     rsp_q;

   // a non-final byte never needs the result register
   assign proc       = in_valid_ff && (!in_last_ff || !rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || proc;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= TAG_RESET;
      end else if (csr_valid && csr_ready) begin
         tag_ff <= csr_data;
      end
   end

   ngga_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (proc),
      .rx_byte (in_byte_ff),
      .last    (in_last_ff),
      .tag     (tag_ff),
      .rsp     (rsp_next)
   );

   ngga_out_reg u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (proc && in_last_ff),
      .rsp_in  (rsp_next),
      .take    (rsp_tready),
      .valid   (rsp_tvalid),
      .rsp_out (rsp_q)
   );

   assign rsp_tdata    = rsp_q.rec;
   assign rsp_tuser[0] = rsp_q.sentence_seen;

   `NGGA_ASSERT_NEXT(a_last_gives_rsp, clock, reset, proc && in_last_ff, rsp_tvalid, "end-of-buffer word produced no record")
   `NGGA_ASSERT_NOW(a_stall_only_on_last, clock, reset, !req_tready, in_valid_ff && in_last_ff && rsp_tvalid, "input stalled without a blocked record")

endmodule

>>> design/ngga_parse.sv
// Per-byte sentence parser: header match, field counting and field stores.
// Depends on ngga_pkg and nmea_gga_field_extractor_defines.svh.
`include "nmea_gga_field_extractor_defines.svh"

module ngga_parse (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [7:0]                    rx_byte,
   input  logic                          last,
   input  logic [ngga_pkg::TAG_W-1:0]    tag,
   output ngga_pkg::ngga_rsp_type        rsp
);
   import ngga_pkg::*;

   logic [2:0] hp_ff, hp_in;
   logic       match_ff, match_in;
   logic [2:0] fi_ff, fi_in, fi_nx;
   logic [3:0] ci_ff, ci_in;
   byte_type   time_ff [TIME_LEN];
   byte_type   time_in [TIME_LEN];
   byte_type   lat_ff [LAT_LEN];
   byte_type   lat_in [LAT_LEN];
   byte_type   lon_ff [LON_LEN];
   byte_type   lon_in [LON_LEN];
   byte_type   sats_ff, sats_in;
   logic       seen_ff, seen_in;
   logic [2:0] tag_sel;
   byte_type   tag_byte;

   always_comb begin
      hp_in    = hp_ff;
      match_in = match_ff;
      fi_in    = fi_ff;
      ci_in    = ci_ff;
      time_in  = time_ff;
      lat_in   = lat_ff;
      lon_in   = lon_ff;
      sats_in  = sats_ff;
      seen_in  = seen_ff;
      fi_nx    = (fi_ff == FIELD_MAX) ? fi_ff : fi_ff + 3'd1;
      tag_sel  = 3'(HDR_LEN - 1) - hp_ff;
      // first tag char sits in the top byte
      tag_byte = (hp_ff < 3'(HDR_LEN)) ? tag[{tag_sel, 3'b000} +: 8] : 8'h00;

      if (rx_byte == START_CHAR) begin
         hp_in    = 3'd0;
         match_in = 1'b1;
         fi_in    = 3'd0;
         ci_in    = 4'd0;
      end else if (hp_ff < 3'(HDR_LEN)) begin
         if (rx_byte != tag_byte) begin
            match_in = 1'b0;
         end
         hp_in = hp_ff + 3'd1;
      end else if (hp_ff == 3'(HDR_LEN)) begin
         // byte after the tag is skipped; body starts here
         hp_in = 3'(BODY_POS);
         fi_in = 3'd0;
         ci_in = 4'd0;
         if (match_ff) begin
            seen_in = 1'b1;
            for (int i = 0; i < TIME_LEN; i++) time_in[i] = 8'h00;
         end
      end else if (match_ff) begin
         if (rx_byte == SEP_CHAR) begin
            fi_in = fi_nx;
            ci_in = 4'd0;
            case (fi_nx)
               FLD_LAT: begin
                  for (int i = 0; i < LAT_LEN; i++) lat_in[i] = 8'h00;
               end
               FLD_LON: begin
                  for (int i = 0; i < LON_LEN; i++) lon_in[i] = 8'h00;
               end
               FLD_SATS: begin
                  sats_in = 8'h00;
               end
               default: begin
               end
            endcase
         end else begin
            case (fi_ff)
               FLD_TIME: begin
                  for (int i = 0; i < TIME_LEN; i++)
                     if (4'(i) == ci_ff) time_in[i] = rx_byte;
               end
               FLD_LAT: begin
                  for (int i = 0; i < LAT_LEN; i++)
                     if (4'(i) == ci_ff) lat_in[i] = rx_byte;
               end
               FLD_LON: begin
                  for (int i = 0; i < LON_LEN; i++)
                     if (4'(i) == ci_ff) lon_in[i] = rx_byte;
               end
               FLD_SATS: begin
                  if (ci_ff == 4'd0) sats_in = rx_byte;
               end
               default: begin
               end
            endcase
            if (ci_ff != CHAR_MAX) ci_in = ci_ff + 4'd1;
         end
      end
   end

   // record as it stands after this byte
   assign rsp.rec.time_head = {time_in[0], time_in[1], time_in[2],
                               time_in[3], time_in[4], time_in[5]};
   assign rsp.rec.time_tail = {time_in[6], time_in[7], time_in[8], time_in[9]};
   assign rsp.rec.lat_head  = {lat_in[0], lat_in[1], lat_in[2], lat_in[3], lat_in[4]};
   assign rsp.rec.lat_tail  = {lat_in[5], lat_in[6], lat_in[7], lat_in[8]};
   assign rsp.rec.lon_head  = {lon_in[0], lon_in[1], lon_in[2], lon_in[3], lon_in[4]};
   assign rsp.rec.lon_tail  = {lon_in[5], lon_in[6], lon_in[7], lon_in[8], lon_in[9]};
   assign rsp.rec.sats_char = sats_in;
   assign rsp.sentence_seen = seen_in;

   always_ff @(posedge clock) begin
      if (reset || (step && last)) begin
         hp_ff    <= 3'd0;
         match_ff <= 1'b1;
         fi_ff    <= 3'd0;
         ci_ff    <= 4'd0;
         for (int i = 0; i < TIME_LEN; i++) time_ff[i] <= 8'h00;
         for (int i = 0; i < LAT_LEN; i++) lat_ff[i] <= 8'h00;
         for (int i = 0; i < LON_LEN; i++) lon_ff[i] <= 8'h00;
         sats_ff  <= ZERO_CHAR;
         seen_ff  <= 1'b0;
      end else if (step) begin
         hp_ff    <= hp_in;
         match_ff <= match_in;
         fi_ff    <= fi_in;
         ci_ff    <= ci_in;
         time_ff  <= time_in;
         lat_ff   <= lat_in;
         lon_ff   <= lon_in;
         sats_ff  <= sats_in;
         seen_ff  <= seen_in;
      end
   end

   `NGGA_ASSERT_NOW(a_field_in_body, clock, reset, fi_ff != 3'd0, hp_ff == 3'(BODY_POS), "field count outside sentence body")
   `NGGA_ASSERT_NOW(a_char_in_match, clock, reset, ci_ff != 4'd0, (hp_ff == 3'(BODY_POS)) && match_ff, "chars counted in unmatched sentence")
   `NGGA_ASSERT_NEXT(a_clear_on_last, clock, reset, step && last, (hp_ff == 3'd0) && !seen_ff && (sats_ff == ZERO_CHAR), "parser not cleared after end of buffer")

endmodule

>>> design/ngga_out_reg.sv
// Result register holding one packed record until the consumer takes it.
// Depends on ngga_pkg.
module ngga_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ngga_pkg::ngga_rsp_type rsp_in,
   input  logic                   take,
   output logic                   valid,
   output ngga_pkg::ngga_rsp_type rsp_out
);
   import ngga_pkg::*;

   logic         valid_ff;
   ngga_rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign valid   = valid_ff;
   assign rsp_out = rsp_ff;

endmodule
